// File: sv/pid_position_with_release_exit_assert.svh
// Assertion macros for the controller top level.
`ifndef PID_POSITION_WITH_RELEASE_EXIT_ASSERT_SVH
`define PID_POSITION_WITH_RELEASE_EXIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PWRE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define PWRE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define PWRE_ASSERT_NOW(label, clk, rst, ante, cons)
`define PWRE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: sv/pwre_pkg.sv
// Types, codes and saturation helpers for the position controller.
package pwre_pkg;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [2:0] REG_GAIN_P    = 3'd0;
  localparam logic [2:0] REG_GAIN_I    = 3'd1;
  localparam logic [2:0] REG_GAIN_D    = 3'd2;
  localparam logic [2:0] REG_VEL_LIMIT = 3'd3;
  localparam logic [2:0] REG_EXIT_SPD  = 3'd4;

  localparam logic [15:0] RST_GAIN_P    = 16'd77;
  localparam logic [15:0] RST_GAIN_I    = 16'd51;
  localparam logic [15:0] RST_GAIN_D    = 16'd77;
  localparam logic [7:0]  RST_VEL_LIMIT = 8'd80;
  localparam logic [7:0]  RST_EXIT_SPD  = 8'd10;

  // integral term is capped to +/- 2^60
  localparam logic signed [63:0] TERM_CAP = 64'sh1000_0000_0000_0000;

  typedef enum logic [1:0] {
    STAT_RUN     = 2'd0,
    STAT_REACHED = 2'd1,
    STAT_RELEASE = 2'd2,
    STAT_THERE   = 2'd3
  } pwre_status_t;

  typedef struct packed {
    logic [15:0] gain_proportional;
    logic [15:0] gain_integral;
    logic [15:0] gain_derivative;
    logic [7:0]  velocity_limit;
    logic [7:0]  exit_speed;
  } pwre_cfg_t;

  typedef struct packed {
    logic signed [31:0] goal;
    logic signed [31:0] zero_point;
    logic signed [31:0] last_error;
    logic signed [47:0] error_sum;
    logic signed [15:0] clamp_count;
    logic               moving;
  } pwre_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
    logic signed [47:0] r;
    if (v[48] != v[47]) begin
      r = v[48] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    logic signed [15:0] r;
    if (v[16] != v[15]) begin
      r = v[16] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// File: sv/pwre_in_if.sv
// Input item channel: command, target and raw position.
interface pwre_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [31:0] target;
  logic signed [31:0] position;

  modport source (output valid, cmd, target, position, input ready);
  modport sink (input valid, cmd, target, position, output ready);
endinterface

// File: sv/pwre_out_if.sv
// Result channel: velocity command and move status.
interface pwre_out_if;
  logic              valid;
  logic              ready;
  logic signed [8:0] velocity;
  logic [1:0]        status;

  modport source (output valid, velocity, status, input ready);
  modport sink (input valid, velocity, status, output ready);
endinterface

// File: sv/pwre_cfg_regs.sv
// Configuration register file: gains, clamp limit and exit speed.
module pwre_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output pwre_pkg::pwre_cfg_t cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_proportional <= pwre_pkg::RST_GAIN_P;
      cfg.gain_integral     <= pwre_pkg::RST_GAIN_I;
      cfg.gain_derivative   <= pwre_pkg::RST_GAIN_D;
      cfg.velocity_limit    <= pwre_pkg::RST_VEL_LIMIT;
      cfg.exit_speed        <= pwre_pkg::RST_EXIT_SPD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pwre_pkg::REG_GAIN_P:    cfg.gain_proportional <= cfg_data;
        pwre_pkg::REG_GAIN_I:    cfg.gain_integral     <= cfg_data;
        pwre_pkg::REG_GAIN_D:    cfg.gain_derivative   <= cfg_data;
        pwre_pkg::REG_VEL_LIMIT: cfg.velocity_limit    <= cfg_data[7:0];
        pwre_pkg::REG_EXIT_SPD:  cfg.exit_speed        <= cfg_data[7:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

endmodule

// File: sv/pwre_step.sv
// One control step: error terms, PID sum, clamp and exit decision.
module pwre_step (
  input  pwre_pkg::pwre_cfg_t    cfg,
  input  pwre_pkg::pwre_state_t  st,
  input  logic                   cmd,
  input  logic signed [31:0]     target,
  input  logic signed [31:0]     position,
  output pwre_pkg::pwre_state_t  st_next,
  output logic signed [8:0]      velocity,
  output pwre_pkg::pwre_status_t status
);

  logic signed [31:0] rel;
  logic signed [31:0] err;
  logic signed [31:0] deriv;
  logic signed [47:0] sum_acc;
  logic signed [47:0] sum_new;
  logic signed [16:0] kp;
  logic signed [16:0] ki;
  logic signed [16:0] kd;
  logic signed [48:0] pterm;
  logic signed [48:0] dterm;
  logic signed [63:0] iprod;
  logic signed [63:0] iterm;
  logic signed [63:0] total;
  logic signed [63:0] quot;
  logic signed [55:0] vel_q;
  logic signed [55:0] lim;
  logic signed [9:0]  vel_c;
  logic signed [9:0]  ex;
  logic signed [15:0] cc_new;
  logic               release_exit;

  assign kp = $signed({1'b0, cfg.gain_proportional});
  assign ki = $signed({1'b0, cfg.gain_integral});
  assign kd = $signed({1'b0, cfg.gain_derivative});

  assign rel     = pwre_pkg::sat32(33'(position) - 33'(st.zero_point));
  assign err     = pwre_pkg::sat32(33'(st.goal) - 33'(rel));
  assign deriv   = pwre_pkg::sat32(33'(err) - 33'(st.last_error));
  assign sum_acc = pwre_pkg::sat48(49'(st.error_sum) + 49'(err));
  // integral only survives while rel is above the goal
  assign sum_new = (err == 32'sd0 || rel < st.goal) ? 48'sd0 : sum_acc;

  assign pterm = 49'(kp) * 49'(err);
  assign dterm = 49'(kd) * 49'(deriv);
  assign iprod = 64'(ki) * 64'(sum_new);

  always_comb begin
    if (iprod > pwre_pkg::TERM_CAP) begin
      iterm = pwre_pkg::TERM_CAP;
    end else if (iprod < -pwre_pkg::TERM_CAP) begin
      iterm = -pwre_pkg::TERM_CAP;
    end else begin
      iterm = iprod;
    end
  end

  assign total = 64'(pterm) + 64'(dterm) + iterm;
  // divide by 256, rounding toward zero
  assign quot  = total[63] ? ((total + 64'sd255) >>> 8) : (total >>> 8);
  assign vel_q = quot[55:0];
  assign lim   = $signed({48'd0, cfg.velocity_limit});
  assign ex    = $signed({2'd0, cfg.exit_speed});

  always_comb begin
    if (vel_q > lim) begin
      vel_c  = 10'(lim);
      cc_new = pwre_pkg::sat16(17'(st.clamp_count) + 17'sd1);
    end else if (vel_q < -lim) begin
      vel_c  = -10'(lim);
      cc_new = pwre_pkg::sat16(17'(st.clamp_count) - 17'sd1);
    end else begin
      vel_c  = vel_q[9:0];
      cc_new = st.clamp_count;
    end
  end

  assign release_exit = (cc_new > 16'sd0 && vel_c < ex) ||
                        (cc_new < 16'sd0 && vel_c > -ex);

  always_comb begin
    st_next  = st;
    velocity = 9'sd0;
    status   = pwre_pkg::STAT_RUN;
    if (cmd == pwre_pkg::CMD_START) begin
      if (position == target) begin
        st_next.moving = 1'b0;
        status         = pwre_pkg::STAT_THERE;
      end else begin
        st_next.goal        = target;
        st_next.zero_point  = position;
        st_next.last_error  = 32'sd0;
        st_next.error_sum   = 48'sd0;
        st_next.clamp_count = 16'sd0;
        st_next.moving      = 1'b1;
      end
    end else if (st.moving) begin
      st_next.error_sum   = sum_new;
      st_next.clamp_count = cc_new;
      if (release_exit) begin
        st_next.moving = 1'b0;
        status         = pwre_pkg::STAT_RELEASE;
      end else begin
        st_next.last_error = err;
        velocity           = vel_c[8:0];
        if (rel == st.goal) begin
          st_next.moving = 1'b0;
          status         = pwre_pkg::STAT_REACHED;
        end
      end
    end
  end

endmodule

// File: sv/pid_position_with_release_exit.sv
// Top level of the position PID controller with release exit.
//
//   channel  dir  handshake          payload
//   item     in   valid/ready        cmd, target, position
//   result   out  valid/ready        velocity, status
//   cfg      in   cfg_we (no stall)  cfg_index, cfg_data
//
// One item per cycle sustained while the result is not stalled; an item is captured
// in the input register, then loaded into the result register, from which it transfers.
// All step math sits between the input register and the result register;
// the controller state is written as the item moves into the result register.
// Reset clears the valid flags and the controller state, and loads default gains.
// A stalled result holds both stages; the input register still takes an item
// while the result waits, so item.ready drops only when both are full.
`include "pid_position_with_release_exit_assert.svh"

module pid_position_with_release_exit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  pwre_in_if.sink     item,
  pwre_out_if.source  result
);

  pwre_pkg::pwre_cfg_t    cfg;
  pwre_pkg::pwre_state_t  st;
  pwre_pkg::pwre_state_t  st_next;
  pwre_pkg::pwre_status_t step_status;
  logic signed [8:0]      step_velocity;

  // input register
  logic               s1_valid;
  logic               s1_cmd;
  logic signed [31:0] s1_target;
  logic signed [31:0] s1_position;

  // result register
  logic                   res_valid;
  logic signed [8:0]      res_velocity;
  pwre_pkg::pwre_status_t res_status;

  logic advance;

  pwre_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pwre_step u_step (
    .cfg      (cfg),
    .st       (st),
    .cmd      (s1_cmd),
    .target   (s1_target),
    .position (s1_position),
    .st_next  (st_next),
    .velocity (step_velocity),
    .status   (step_status)
  );

  // Advance whenever the result register is empty or being drained.
  assign advance    = !res_valid || result.ready;
  assign item.ready = !s1_valid || advance;

  // Capture a new item on every input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      s1_cmd      <= item.cmd;
      s1_target   <= item.target;
      s1_position <= item.position;
    end
  end

  // Commit the step: controller state and the result move together.
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
      if (s1_valid) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      res_velocity <= step_velocity;
      res_status   <= step_status;
    end
  end

  assign result.valid    = res_valid;
  assign result.velocity = res_velocity;
  assign result.status   = res_status;

  // No item moves forward, so the controller state must hold.
  `PWRE_ASSERT_NEXT(a_state_hold, clk, rst, !advance, $stable(st))
  // A release exit always commands zero velocity.
  `PWRE_ASSERT_NOW(a_release_zero, clk, rst,
                   res_valid && res_status == pwre_pkg::STAT_RELEASE, res_velocity == 9'sd0)
  // Any finishing status leaves the controller idle.
  `PWRE_ASSERT_NEXT(a_finish_idle, clk, rst,
                    advance && s1_valid && step_status != pwre_pkg::STAT_RUN, !st.moving)

endmodule

// File: tb/sv/pwre_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the position controller: command predictor and queue of expected results.
package pwre_tb_pkg;
  import pwre_pkg::*;

  typedef struct packed {
    logic signed [8:0] velocity;
    pwre_status_t      status;
  } motor_cmd_t;

  function automatic longint clip(input longint v, input int unsigned bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  class motor_cmd_scoreboard;
    logic [15:0]        kp;
    logic [15:0]        ki;
    logic [15:0]        kd;
    logic [7:0]         vlim;
    logic [7:0]         xspd;
    logic signed [31:0] goal;
    logic signed [31:0] zero_point;
    logic signed [31:0] last_error;
    logic signed [47:0] error_sum;
    logic signed [15:0] clamp_count;
    logic               moving;
    motor_cmd_t         expected_cmds[$];
    int                 failures;

    function new();
      kp = RST_GAIN_P;
      ki = RST_GAIN_I;
      kd = RST_GAIN_D;
      vlim = RST_VEL_LIMIT;
      xspd = RST_EXIT_SPD;
      goal = '0;
      zero_point = '0;
      last_error = '0;
      error_sum = '0;
      clamp_count = '0;
      moving = 1'b0;
      failures = 0;
    endfunction

    function void set_reg(input logic [2:0] idx, input logic [15:0] data);
      case (idx)
        REG_GAIN_P:    kp = data;
        REG_GAIN_I:    ki = data;
        REG_GAIN_D:    kd = data;
        REG_VEL_LIMIT: vlim = data[7:0];
        REG_EXIT_SPD:  xspd = data[7:0];
        default: ;
      endcase
    endfunction

    // advance the controller state by one item and return the command it yields
    function motor_cmd_t predict_command(input logic cmd, input logic signed [31:0] tgt,
                                         input logic signed [31:0] pos);
      motor_cmd_t r;
      longint rel, err, es, deriv, iterm, vel, cc, gp, gi, gd, lim, ex;
      r.velocity = '0;
      r.status = STAT_RUN;
      if (cmd == CMD_START) begin
        if (pos == tgt) begin
          moving = 1'b0;
          r.status = STAT_THERE;
        end else begin
          goal = tgt;
          zero_point = pos;
          last_error = '0;
          error_sum = '0;
          clamp_count = '0;
          moving = 1'b1;
        end
        return r;
      end
      if (!moving) return r;

      gp = kp;
      gi = ki;
      gd = kd;
      lim = vlim;
      ex = xspd;
      rel = clip(longint'(pos) - longint'(zero_point), 32);
      err = clip(longint'(goal) - rel, 32);
      es = clip(longint'(error_sum) + err, 48);
      if (err == 0 || rel < longint'(goal)) es = 0;
      error_sum = es[47:0];
      deriv = clip(err - longint'(last_error), 32);
      iterm = clip(gi * es, 62);
      if (iterm > TERM_CAP) iterm = TERM_CAP;
      if (iterm < -TERM_CAP) iterm = -TERM_CAP;
      vel = (gp * err + iterm + gd * deriv) / 256;

      cc = clamp_count;
      if (vel > lim) begin
        vel = lim;
        cc = clip(cc + 1, 16);
      end else if (vel < -lim) begin
        vel = -lim;
        cc = clip(cc - 1, 16);
      end
      clamp_count = cc[15:0];

      if ((cc > 0 && vel < ex) || (cc < 0 && vel > -ex)) begin
        moving = 1'b0;
        r.status = STAT_RELEASE;
        return r;
      end
      last_error = err[31:0];
      r.velocity = vel[8:0];
      if (rel == longint'(goal)) begin
        moving = 1'b0;
        r.status = STAT_REACHED;
      end
      return r;
    endfunction

    function void note_item(input logic cmd, input logic signed [31:0] tgt,
                            input logic signed [31:0] pos);
      expected_cmds.push_back(predict_command(cmd, tgt, pos));
    endfunction

    function void check_result(input logic signed [8:0] vel, input logic [1:0] stat);
      motor_cmd_t want;
      if (expected_cmds.size() == 0) begin
        failures++;
        $display("%0t: result expected none actual velocity %0d status %0d",
                 $time, vel, stat);
        return;
      end
      want = expected_cmds.pop_front();
      if (vel !== want.velocity) begin
        failures++;
        $display("%0t: velocity expected %0d actual %0d", $time, want.velocity, vel);
      end
      if (stat !== want.status) begin
        failures++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, stat);
      end
    endfunction

    function int pending();
      return expected_cmds.size();
    endfunction
  endclass

endpackage

// File: tb/sv/tb_pid_position_with_release_exit.sv
`timescale 1ns / 1ps
// Testbench top for the position controller: directed moves, random moves and windup runs.
module tb_pid_position_with_release_exit;
  import pwre_pkg::*;
  import pwre_tb_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  pwre_in_if  item ();
  pwre_out_if result ();

  // percent of cycles in which the sender holds off and the receiver stalls
  int src_idle;
  int dst_idle;
  // items transferred in the current phase, used only to stop the random stimulus
  int sent;

  motor_cmd_scoreboard sb = new();

  pid_position_with_release_exit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item.sink),
    .result    (result.source)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs; far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver: stall at random at the rate of the current phase.
  initial begin
    result.ready = 1'b0;
    forever begin
      @(posedge clk);
      result.ready <= ($urandom_range(99) >= dst_idle);
    end
  end

  // Check every result transfer against the oldest expected command.
  always @(posedge clk) begin
    if (!rst && result.valid && result.ready) begin
      sb.check_result(result.velocity, result.status);
    end
  end

  function automatic logic signed [31:0] rnd32();
    logic signed [31:0] w;
    w = $urandom();
    return w;
  endfunction

  // Transfer one item. Optionally hold off first; valid is lowered only at the
  // step where the gap starts and raised again at a later step.
  task automatic send_item(input logic c, input logic signed [31:0] t,
                           input logic signed [31:0] p);
    if (src_idle > 0 && $urandom_range(99) < src_idle) begin
      item.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle);
    end
    item.valid    <= 1'b1;
    item.cmd      <= c;
    item.target   <= t;
    item.position <= p;
    do @(posedge clk); while (!item.ready);
    sb.note_item(c, t, p);
    sent++;
  endtask

  // Drop valid, wait for every expected result, then let the pipeline settle.
  task automatic drain();
    item.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  // Write all five registers plus a write to an unused index, which must be
  // ignored. The 8-bit registers get junk in the upper byte of the data.
  task automatic program_regs(input logic [15:0] gp, input logic [15:0] gi,
                              input logic [15:0] gd, input logic [7:0] lim,
                              input logic [7:0] ex);
    logic [7:0] junk;
    junk = 8'($urandom());
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_GAIN_D, gd);
    write_reg(REG_VEL_LIMIT, {junk, lim});
    write_reg(REG_EXIT_SPD, {~junk, ex});
    write_reg(REG_EXIT_SPD + 3'd1 + 3'($urandom_range(2)), 16'($urandom()));
    cfg_we <= 1'b0;
  endtask

  // Idle pattern: sender light and receiver heavy, then the reverse, then none.
  task automatic set_mode(input int m);
    case (m % 3)
      0: begin src_idle = 12; dst_idle = 84; end
      1: begin src_idle = 84; dst_idle = 12; end
      default: begin src_idle = 0; dst_idle = 0; end
    endcase
  endtask

  // One move: a start, then ticks that approach, land on, overshoot or jump
  // away from the target. Stop when the ticks run out or shortly after the controller ends the move.
  task automatic random_move();
    longint z, tgt, cur, rem;
    logic signed [31:0] p;
    int n, pick, i;
    if ($urandom_range(7) == 0) z = longint'(rnd32());
    else z = longint'($urandom_range(200000)) - 100000;
    if ($urandom_range(9) == 0) tgt = longint'(rnd32());
    else begin
      tgt = longint'($urandom_range(3000));
      if ($urandom_range(1) == 1) tgt = -tgt;
    end
    if ($urandom_range(15) == 0) begin
      // already there: start at the target itself
      send_item(CMD_START, tgt[31:0], tgt[31:0]);
      send_item(CMD_TICK, rnd32(), rnd32());
      return;
    end
    send_item(CMD_START, tgt[31:0], z[31:0]);
    cur = 0;
    n = $urandom_range(1, 30);
    for (i = 0; i < n; i++) begin
      rem = tgt - cur;
      pick = $urandom_range(9);
      if (pick <= 2) cur = tgt;
      else if (pick <= 6) cur = cur + rem * longint'($urandom_range(1, 9)) / 10;
      else if (pick == 7) cur = cur + rem * longint'($urandom_range(11, 15)) / 10;
      p = 32'(z + cur);
      if (pick == 9) p = rnd32();
      send_item(CMD_TICK, rnd32(), p);
      if (!sb.moving) begin
        // one idle tick now and then after the move ends
        if ($urandom_range(1) == 0) send_item(CMD_TICK, rnd32(), rnd32());
        break;
      end
    end
  endtask

  task automatic run_phase(input int m, input int quota);
    set_mode(m);
    sent = 0;
    while (sent < quota) random_move();
    drain();
  endtask

  // Run against a target that is never reached so the clamp counter, and in the downward run
  // the integral too, build up at their fastest rate; then land on it.
  task automatic windup(input bit upward, input int ticks);
    if (upward) begin
      send_item(CMD_START, 32'sh7FFF_FFFF, 32'sd0);
      repeat (ticks) send_item(CMD_TICK, rnd32(), 32'sh8000_0000);
      send_item(CMD_TICK, rnd32(), 32'sh7FFF_FFFF);
    end else begin
      send_item(CMD_START, 32'sh8000_0000, 32'sd0);
      repeat (ticks) send_item(CMD_TICK, rnd32(), 32'sh7FFF_FFFF);
      send_item(CMD_TICK, rnd32(), 32'sh8000_0000);
    end
  endtask

  initial begin
    int ph;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    item.valid    = 1'b0;
    item.cmd      = CMD_START;
    item.target   = '0;
    item.position = '0;
    src_idle      = 12;
    dst_idle      = 84;
    sent          = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed moves under the reset gains.
    set_mode(0);
    send_item(CMD_TICK, 32'sd77, 32'sd12345);           // idle tick
    send_item(CMD_START, 32'sd5, 32'sd5);               // already there
    send_item(CMD_START, 32'sd2000, 32'sd0);            // clamp high, then slow: release
    send_item(CMD_TICK, 32'sd0, 32'sd0);
    send_item(CMD_TICK, 32'sd0, 32'sd1000);
    send_item(CMD_START, 32'sd100, 32'sd1000);          // approach and reach
    send_item(CMD_TICK, 32'sd0, 32'sd1050);
    send_item(CMD_TICK, 32'sd0, 32'sd1100);
    send_item(CMD_START, 32'sd100, 32'sd0);             // overshoot builds the integral
    send_item(CMD_TICK, 32'sd0, 32'sd300);
    send_item(CMD_TICK, 32'sd0, 32'sd300);
    send_item(CMD_TICK, 32'sd0, 32'sd100);
    send_item(CMD_START, -32'sd2000, -32'sd50);         // clamp low on both ticks, no release
    send_item(CMD_TICK, 32'sd0, -32'sd50);
    send_item(CMD_TICK, 32'sd0, -32'sd1050);
    send_item(CMD_START, 32'sh7FFF_FFFF, 32'sh8000_0000); // extremes, saturated relative position
    send_item(CMD_TICK, 32'sd0, 32'sh7FFF_FFFF);
    send_item(CMD_TICK, 32'sd0, 32'sh8000_0000);
    send_item(CMD_START, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_item(CMD_TICK, -32'sd1, 32'sh8000_0000);
    send_item(CMD_TICK, -32'sd1, 32'sh7FFF_FFFF);
    send_item(CMD_START, 32'sd0, 32'sd7);               // zero target, reached at once
    send_item(CMD_TICK, 32'sd0, 32'sd7);
    send_item(CMD_START, 32'sd50, 32'sd3);              // restart while moving
    send_item(CMD_START, 32'sd60, 32'sd9);
    send_item(CMD_TICK, 32'sd0, 32'sd69);
    drain();

    // Random moves over several register settings, extremes included.
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: ;                                             // reset values
        1: program_regs(16'd0, 16'd0, 16'd0, 8'd0, 8'd0);
        2: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255);
        3: program_regs(16'($urandom_range(1023)), 16'($urandom_range(1023)),
                        16'($urandom_range(1023)), 8'($urandom_range(255)),
                        8'($urandom_range(255)));
        4: program_regs(16'($urandom()), 16'($urandom()), 16'($urandom()), 8'd255, 8'd0);
        default: program_regs(RST_GAIN_P, RST_GAIN_I, RST_GAIN_D, RST_VEL_LIMIT,
                              RST_EXIT_SPD);
      endcase
      run_phase(ph, 240);
    end

    // Windup runs at full rate with the largest integral gain.
    set_mode(2);
    program_regs(16'd256, 16'hFFFF, 16'd256, 8'd255, 8'd0);
    windup(1'b0, 20);
    windup(1'b1, 20);
    drain();

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: pid_position_with_release_exit.f
+incdir+sv
sv/pwre_pkg.sv
sv/pwre_in_if.sv
sv/pwre_out_if.sv
sv/pwre_cfg_regs.sv
sv/pwre_step.sv
sv/pid_position_with_release_exit.sv
tb/sv/pwre_tb_pkg.sv
tb/sv/tb_pid_position_with_release_exit.sv
